### rtl/lzfg_pkg.sv
// ----------------------------------------------------------------------------
// lzfg_pkg
// Shared constants and types for the flag-group LZ decompressor.
// ----------------------------------------------------------------------------
package lzfg_pkg;

    localparam int unsigned DEF_HISTORY_DEPTH = 8192;

    localparam logic [7:0] MAGIC_COMPRESSED = 8'h04;
    localparam logic [7:0] MAGIC_REWRITE    = 8'h03;
    localparam logic [3:0] HDR_DEFAULT      = 4'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_PASS  = 2'd1;
    localparam logic [1:0] STAT_TRUNC = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       eop;
        logic       valid;
        logic [7:0] data;
    } t_result;

endpackage

### rtl/lzfg_ram.sv
// ----------------------------------------------------------------------------
// lzfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzfg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lz_flag_group_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz_flag_group_decompressor_top
// Byte-stream decompressor for flag-group LZ packets with 12-bit offsets.
// ----------------------------------------------------------------------------
// Packet bytes enter on the s_axis channel (tlast marks the final byte) and
// decompressed bytes leave on the m_axis channel. tuser carries the byte
// valid flag and the packet status; tlast marks the last result of a packet.
// A packet not starting with 0x04 passes through unchanged with status 1.
// The header length is written on i_cfg_we/i_cfg_wdata and latched at the
// first byte of each packet.
// Pass-through, header, literal, flag and token low bytes are taken back to
// back unless the output stalls; any result they give appears in the cycle
// after the transfer. A match token's high byte starts a copy of 2 to 17
// bytes, each read from the history RAM and then written back and emitted.
// Input is not accepted during a copy. When the receiver stalls, the output
// register holds its result and the sequencer waits; no result is dropped.
// Reset returns the block to idle with a header length of 3; the history RAM
// is not cleared: reads of positions not yet written return zero instead.
// ----------------------------------------------------------------------------
module lz_flag_group_decompressor_top
    import lzfg_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic       o_m_axis_tlast
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [16:0] DEPTH_W = 17'(HISTORY_DEPTH);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PASS    = 3'd1;
    localparam logic [2:0] MODE_HEADER  = 3'd2;
    localparam logic [2:0] MODE_FLAG    = 3'd3;
    localparam logic [2:0] MODE_ITEM    = 3'd4;
    localparam logic [2:0] MODE_TOKHI   = 3'd5;
    localparam logic [2:0] MODE_DISCARD = 3'd6;

    localparam logic [1:0] SEQ_IN = 2'd0;
    localparam logic [1:0] SEQ_RD = 2'd1;
    localparam logic [1:0] SEQ_WR = 2'd2;

    logic [1:0]  r_seq, n_seq;
    logic [2:0]  r_mode, n_mode;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [7:0]  r_flags, n_flags;
    logic [3:0]  r_fidx, n_fidx;
    logic [7:0]  r_toklo, n_toklo;
    logic [15:0] r_pos, n_pos;
    logic [3:0]  r_hdr_cfg;
    logic [3:0]  r_hdr_len, n_hdr_len;
    logic [15:0] r_src, n_src;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        r_done, n_done;
    logic        r_zero, n_zero;
    logic        r_ovalid, n_ovalid;
    t_result     r_out, n_out;

    logic          accept;
    logic          slot_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign slot_free       = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_seq == SEQ_IN) && slot_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [7:0]  b;
        logic        last;
        logic        do_put;
        logic [7:0]  put_val;
        logic [15:0] pos_base;
        logic [3:0]  hdr_new;
        logic [3:0]  hcnt_inc;
        logic [3:0]  fidx_inc;
        logic [11:0] off;
        logic        fin;
        logic [7:0]  v;

        b        = i_s_axis_tdata;
        last     = i_s_axis_tlast;
        do_put   = 1'b0;
        put_val  = b;
        pos_base = r_pos;
        hdr_new  = (r_hdr_cfg == 4'd0) ? 4'd1 : r_hdr_cfg;
        hcnt_inc = r_hcnt + 4'd1;
        fidx_inc = r_fidx + 4'd1;
        off      = {b, r_toklo[7:4]};
        fin      = 1'b0;
        v        = 8'd0;

        n_seq     = r_seq;
        n_mode    = r_mode;
        n_hcnt    = r_hcnt;
        n_flags   = r_flags;
        n_fidx    = r_fidx;
        n_toklo   = r_toklo;
        n_pos     = r_pos;
        n_hdr_len = r_hdr_len;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_done    = r_done;
        n_zero    = r_zero;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_out     = r_out;
        ram_re    = 1'b0;
        ram_raddr = r_src[AW-1:0];

        case (r_seq)
            SEQ_IN: begin
                if (accept) begin
                    case (r_mode)
                        MODE_IDLE: begin
                            if (b != MAGIC_COMPRESSED) begin
                                n_ovalid = 1'b1;
                                n_out    = '{status: STAT_PASS, eop: last, valid: 1'b1,
                                             data: b};
                                n_mode   = last ? MODE_IDLE : MODE_PASS;
                            end else begin
                                n_hdr_len = hdr_new;
                                pos_base  = 16'd0;
                                do_put    = 1'b1;
                                put_val   = MAGIC_REWRITE;
                                n_hcnt    = 4'd1;
                                n_ovalid  = 1'b1;
                                if (4'd1 >= hdr_new) begin
                                    n_out  = '{status: STAT_OK, eop: last, valid: 1'b1,
                                               data: MAGIC_REWRITE};
                                    n_mode = last ? MODE_IDLE : MODE_FLAG;
                                end else begin
                                    n_out  = '{status: last ? STAT_TRUNC : STAT_OK,
                                               eop: last, valid: 1'b1,
                                               data: MAGIC_REWRITE};
                                    n_mode = last ? MODE_IDLE : MODE_HEADER;
                                end
                            end
                        end
                        MODE_PASS: begin
                            n_ovalid = 1'b1;
                            n_out    = '{status: STAT_PASS, eop: last, valid: 1'b1, data: b};
                            if (last) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        MODE_HEADER: begin
                            do_put   = 1'b1;
                            n_hcnt   = hcnt_inc;
                            n_ovalid = 1'b1;
                            if (hcnt_inc >= r_hdr_len) begin
                                n_out  = '{status: STAT_OK, eop: last, valid: 1'b1, data: b};
                                n_mode = last ? MODE_IDLE : MODE_FLAG;
                            end else begin
                                n_out  = '{status: last ? STAT_TRUNC : STAT_OK,
                                           eop: last, valid: 1'b1, data: b};
                                n_mode = last ? MODE_IDLE : MODE_HEADER;
                            end
                        end
                        MODE_FLAG: begin
                            n_flags = b;
                            n_fidx  = 4'd0;
                            if (last) begin
                                n_ovalid = 1'b1;
                                n_out    = '{status: STAT_TRUNC, eop: 1'b1, valid: 1'b0,
                                             data: 8'd0};
                                n_mode   = MODE_IDLE;
                            end else begin
                                n_mode = MODE_ITEM;
                            end
                        end
                        MODE_ITEM: begin
                            if (!r_flags[r_fidx[2:0]]) begin
                                do_put   = 1'b1;
                                n_fidx   = fidx_inc;
                                n_ovalid = 1'b1;
                                if (last) begin
                                    n_out  = '{status: fidx_inc[3] ? STAT_OK : STAT_TRUNC,
                                               eop: 1'b1, valid: 1'b1, data: b};
                                    n_mode = MODE_IDLE;
                                end else begin
                                    n_out  = '{status: STAT_OK, eop: 1'b0, valid: 1'b1,
                                               data: b};
                                    n_mode = fidx_inc[3] ? MODE_FLAG : MODE_ITEM;
                                end
                            end else begin
                                n_toklo = b;
                                if (last) begin
                                    n_ovalid = 1'b1;
                                    n_out    = '{status: STAT_TRUNC, eop: 1'b1, valid: 1'b0,
                                                 data: 8'd0};
                                    n_mode   = MODE_IDLE;
                                end else begin
                                    n_mode = MODE_TOKHI;
                                end
                            end
                        end
                        MODE_TOKHI: begin
                            if (off == 12'd0) begin
                                n_ovalid = 1'b1;
                                n_out    = '{status: STAT_OK, eop: 1'b1, valid: 1'b0,
                                             data: 8'd0};
                                n_mode   = last ? MODE_IDLE : MODE_DISCARD;
                            end else begin
                                n_fidx = fidx_inc;
                                n_done = fidx_inc[3];
                                n_last = last;
                                n_cnt  = 5'(r_toklo[3:0]) + 5'd2;
                                n_src  = 16'(off) + 16'(r_hdr_len) - 16'd1;
                                n_seq  = SEQ_RD;
                                n_mode = last ? MODE_IDLE
                                              : (fidx_inc[3] ? MODE_FLAG : MODE_ITEM);
                            end
                        end
                        MODE_DISCARD: begin
                            if (last) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        default: begin
                            n_mode = MODE_IDLE;
                        end
                    endcase
                end
            end
            SEQ_RD: begin
                ram_re = 1'b1;
                n_zero = ({1'b0, r_src} >= DEPTH_W) || (r_src >= r_pos);
                n_seq  = SEQ_WR;
            end
            SEQ_WR: begin
                if (slot_free) begin
                    v        = r_zero ? 8'd0 : ram_rdata;
                    do_put   = 1'b1;
                    put_val  = v;
                    fin      = (r_cnt == 5'd1) && r_last;
                    n_ovalid = 1'b1;
                    n_out    = '{status: (fin && !r_done) ? STAT_TRUNC : STAT_OK,
                                 eop: fin, valid: 1'b1, data: v};
                    n_cnt    = r_cnt - 5'd1;
                    n_src    = r_src + 16'd1;
                    n_seq    = (r_cnt == 5'd1) ? SEQ_IN : SEQ_RD;
                end
            end
            default: begin
                n_seq = SEQ_IN;
            end
        endcase

        ram_we    = do_put && ({1'b0, pos_base} < DEPTH_W);
        ram_waddr = pos_base[AW-1:0];
        ram_wdata = put_val;
        if (do_put) begin
            n_pos = (pos_base == 16'hFFFF) ? pos_base : pos_base + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SEQ_IN;
            r_mode    <= MODE_IDLE;
            r_hcnt    <= 4'd0;
            r_flags   <= 8'd0;
            r_fidx    <= 4'd8;
            r_toklo   <= 8'd0;
            r_pos     <= 16'd0;
            r_hdr_cfg <= HDR_DEFAULT;
            r_hdr_len <= HDR_DEFAULT;
            r_cnt     <= 5'd0;
            r_last    <= 1'b0;
            r_done    <= 1'b0;
            r_zero    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_mode    <= n_mode;
            r_hcnt    <= n_hcnt;
            r_flags   <= n_flags;
            r_fidx    <= n_fidx;
            r_toklo   <= n_toklo;
            r_pos     <= n_pos;
            r_hdr_len <= n_hdr_len;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_done    <= n_done;
            r_zero    <= n_zero;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                r_hdr_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_out <= n_out;
    end

    lzfg_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = {r_out.status, r_out.valid};
    assign o_m_axis_tlast  = r_out.eop;

endmodule

### rtl/lzfg_checker.sv
// ----------------------------------------------------------------------------
// lzfg_checker
// Port-level checks for the flag-group LZ decompressor, bound to the top.
// ----------------------------------------------------------------------------
module lzfg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [2:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready && o_m_axis_tvalid |-> i_m_axis_tready)
        else $error("input taken while output slot is full");

    a_status_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 8'd0 && o_m_axis_tlast)
        else $error("status-only result must be zero and end the packet");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[2:1] != 2'b11)
        else $error("undefined status code");

endmodule

bind lz_flag_group_decompressor_top lzfg_checker u_lzfg_checker (.*);

### tb/tb_lz_flag_group_decompressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_flag_group_decompressor_top
// Self-checking bench for the flag-group LZ decompressor. Packets are driven
// byte by byte on the input stream. A behavioral decoder predicts every
// output transfer. The output stream is checked field by field against it.
// Directed packets cover pass-through, header rewrite, all truncation points,
// matches that read unwritten history and offset-zero end of packet.
// Random packets follow under several header lengths and handshake idle
// patterns.
// ----------------------------------------------------------------------------
module tb_lz_flag_group_decompressor_top;
    import lzfg_pkg::*;

    localparam int HIST_DEPTH   = DEF_HISTORY_DEPTH;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef enum logic [2:0] {
        DEC_IDLE, DEC_PASS, DEC_HEADER, DEC_FLAG, DEC_ITEM, DEC_TOKHI, DEC_DISCARD
    } t_dec_state;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'd0;
    logic       s_tlast   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    int src_gap_pct   = 37;
    int dst_stall_pct = 58;
    int error_count   = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;

    t_dec_state dec_state   = DEC_IDLE;
    logic [3:0] hdr_setting = HDR_DEFAULT;
    logic [3:0] hdr_len     = HDR_DEFAULT;
    logic [3:0] hdr_cnt     = 4'd0;
    logic [7:0] flag_bits   = 8'd0;
    int         flag_pos    = 8;
    logic [7:0] tok_low     = 8'd0;
    int         out_pos     = 0;
    logic [7:0] hist [0:HIST_DEPTH-1];
    t_result    decoded_q [$];

    logic [7:0] pkt_bytes [$];
    int         gen_pos   = 0;
    int         gen_hlen  = 1;

    always #5 clk = ~clk;

    lz_flag_group_decompressor_top #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    function automatic void push_result(logic [7:0] d, logic v, logic e, logic [1:0] s);
        t_result r;
        r.data   = d;
        r.valid  = v;
        r.eop    = e;
        r.status = s;
        decoded_q = {decoded_q, r};
    endfunction

    function automatic logic [7:0] hist_read(int p);
        if (p < out_pos && p < HIST_DEPTH) begin
            return hist[p];
        end
        return 8'h00;
    endfunction

    function automatic void hist_write(logic [7:0] v);
        if (out_pos < HIST_DEPTH) begin
            hist[out_pos] = v;
        end
        if (out_pos < 16'hFFFF) begin
            out_pos++;
        end
    endfunction

    function automatic void header_byte(logic [7:0] v, logic last);
        hist_write(v);
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= hdr_len) begin
            push_result(v, 1'b1, last, STAT_OK);
            dec_state = last ? DEC_IDLE : DEC_FLAG;
        end else begin
            push_result(v, 1'b1, last, last ? STAT_TRUNC : STAT_OK);
            dec_state = last ? DEC_IDLE : DEC_HEADER;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        logic [15:0] tok;
        logic [7:0]  v;
        int          src;
        int          cnt;
        bit          done;
        bit          fin;
        case (dec_state)
            DEC_IDLE: begin
                if (b != MAGIC_COMPRESSED) begin
                    push_result(b, 1'b1, last, STAT_PASS);
                    dec_state = last ? DEC_IDLE : DEC_PASS;
                end else begin
                    hdr_len = (hdr_setting == 4'd0) ? 4'd1 : hdr_setting;
                    out_pos = 0;
                    hdr_cnt = 4'd0;
                    header_byte(MAGIC_REWRITE, last);
                end
            end
            DEC_PASS: begin
                push_result(b, 1'b1, last, STAT_PASS);
                if (last) dec_state = DEC_IDLE;
            end
            DEC_HEADER: header_byte(b, last);
            DEC_FLAG: begin
                flag_bits = b;
                flag_pos  = 0;
                if (last) begin
                    push_result(8'h00, 1'b0, 1'b1, STAT_TRUNC);
                    dec_state = DEC_IDLE;
                end else begin
                    dec_state = DEC_ITEM;
                end
            end
            DEC_ITEM: begin
                if (!flag_bits[flag_pos % 8]) begin
                    hist_write(b);
                    flag_pos++;
                    done = (flag_pos >= 8);
                    if (last) begin
                        push_result(b, 1'b1, 1'b1, done ? STAT_OK : STAT_TRUNC);
                        dec_state = DEC_IDLE;
                    end else begin
                        push_result(b, 1'b1, 1'b0, STAT_OK);
                        dec_state = done ? DEC_FLAG : DEC_ITEM;
                    end
                end else begin
                    tok_low = b;
                    if (last) begin
                        push_result(8'h00, 1'b0, 1'b1, STAT_TRUNC);
                        dec_state = DEC_IDLE;
                    end else begin
                        dec_state = DEC_TOKHI;
                    end
                end
            end
            DEC_TOKHI: begin
                tok = {b, tok_low};
                if (tok[15:4] == 12'd0) begin
                    push_result(8'h00, 1'b0, 1'b1, STAT_OK);
                    dec_state = last ? DEC_IDLE : DEC_DISCARD;
                end else begin
                    cnt = int'(tok[3:0]) + 2;
                    src = int'(tok[15:4]) + int'(hdr_len) - 1;
                    flag_pos++;
                    done = (flag_pos >= 8);
                    for (int i = 0; i < cnt; i++) begin
                        v   = hist_read(src + i);
                        fin = (i + 1 == cnt) && last;
                        hist_write(v);
                        push_result(v, 1'b1, fin, (fin && !done) ? STAT_TRUNC : STAT_OK);
                    end
                    dec_state = last ? DEC_IDLE : (done ? DEC_FLAG : DEC_ITEM);
                end
            end
            DEC_DISCARD: begin
                if (last) dec_state = DEC_IDLE;
            end
            default: dec_state = DEC_IDLE;
        endcase
    endfunction

    // ---- packet builder ----

    function automatic void add_byte(logic [7:0] b);
        pkt_bytes = {pkt_bytes, b};
    endfunction

    function automatic void add_literal(logic [7:0] b);
        add_byte(b);
        gen_pos++;
    endfunction

    function automatic void add_token(int off, int lenm2);
        logic [15:0] tok;
        tok = {off[11:0], lenm2[3:0]};
        add_byte(tok[7:0]);
        add_byte(tok[15:8]);
        gen_pos += lenm2 + 2;
    endfunction

    function automatic int pick_offset();
        int span;
        span = gen_pos - gen_hlen;
        if (span > 4095) span = 4095;
        if (span >= 1 && $urandom_range(99) < 80) begin
            return $urandom_range(span, 1);
        end
        return $urandom_range(4095, 1);
    endfunction

    function automatic void begin_compressed(logic [3:0] hs);
        gen_hlen = (hs == 4'd0) ? 1 : int'(hs);
        add_byte(MAGIC_COMPRESSED);
        repeat (gen_hlen - 1) add_byte(8'($urandom_range(255)));
        gen_pos = gen_hlen;
    endfunction

    function automatic void add_group_items(logic [7:0] flags, int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (flags[k]) begin
                add_token(pick_offset(), $urandom_range(15));
            end else begin
                add_literal(8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic void build_compressed(logic [3:0] hs);
        logic [7:0] flags;
        begin_compressed(hs);
        repeat ($urandom_range(2)) begin
            flags = 8'($urandom_range(255));
            add_byte(flags);
            add_group_items(flags, 8);
        end
        case ($urandom_range(3))
            0: ;
            1: begin
                flags = 8'($urandom_range(255)) | 8'h01;
                add_byte(flags);
                add_byte(8'($urandom_range(15)));
                add_byte(8'h00);
                repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
            end
            2: begin
                flags = 8'($urandom_range(255));
                add_byte(flags);
                add_group_items(flags, $urandom_range(7, 1));
            end
            default: add_byte(8'($urandom_range(255)));
        endcase
    endfunction

    function automatic void build_passthrough();
        logic [7:0] first;
        first = 8'($urandom_range(255));
        if (first == MAGIC_COMPRESSED) first = MAGIC_REWRITE;
        add_byte(first);
        repeat ($urandom_range(9)) add_byte(8'($urandom_range(255)));
    endfunction

    // ---- stream drivers ----

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int n;
        n = pkt_bytes.size();
        for (int k = 0; k < n; k++) begin
            send_byte(pkt_bytes[k], k == n - 1);
        end
        pkt_bytes.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_header_size(input logic [3:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        hdr_setting = v;
    endtask

    // ---- tests ----

    task automatic test_passthrough();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_byte(MAGIC_REWRITE, 1'b1);
    endtask

    task automatic test_truncation();
        // header cut on its first byte, then mid-header
        send_byte(MAGIC_COMPRESSED, 1'b1);
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'hA5, 1'b1);
        // header complete exactly at the end
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        // end right after a flag byte
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h5A, 1'b1);
        // end on a literal inside a group
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h99, 1'b1);
        // end after a token low byte
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h10, 1'b1);
        // end on a match inside a group
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_group_decode();
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h00, 1'b0);
        // shortest match overlapping its own output
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        // longest match at the far offset, unwritten history reads zero
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_offset_zero();
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_header_sizes();
        set_header_size(4'd0);
        send_byte(MAGIC_COMPRESSED, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h13, 1'b0);
        send_byte(8'h00, 1'b1);
        set_header_size(4'd15);
        build_compressed(hdr_setting);
        send_packet();
        set_header_size(4'd1);
        build_compressed(hdr_setting);
        send_packet();
    endtask

    task automatic test_random_packets(input int n_bytes);
        int stop_at;
        int pick;
        int cut;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                build_passthrough();
            end else begin
                build_compressed(hdr_setting);
                if (pick >= 85) begin
                    cut = $urandom_range(pkt_bytes.size(), 1);
                    while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
                end
            end
            send_packet();
        end
    endtask

    // ---- output check ----

    always @(posedge clk) begin : check_results
        t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
        if (rst_n && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected transfer: data %0h user %0h last %0b",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $error("byte_valid: expected %0b, got %0b", want.valid, m_tuser[0]);
                    error_count++;
                end
                if (m_tlast !== want.eop) begin
                    $error("end_of_packet: expected %0b, got %0b", want.eop, m_tlast);
                    error_count++;
                end
                if (m_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** lz_flag_group_decompressor_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_truncation();
        test_group_decode();
        test_offset_zero();
        test_random_packets(40);
        set_header_size(4'd1);
        test_random_packets(40);
        src_gap_pct   = 58;
        dst_stall_pct = 37;
        test_header_sizes();
        set_header_size(4'd15);
        test_random_packets(40);
        set_header_size(4'($urandom_range(14, 2)));
        test_random_packets(40);
        src_gap_pct   = 0;
        dst_stall_pct = 0;
        set_header_size(4'd0);
        test_random_packets(40);
        set_header_size(4'd3);
        test_random_packets(40);
        wait_drained();
        if (error_count == 0) begin
            $display("** lz_flag_group_decompressor_top: PASSED **");
        end else begin
            $display("** lz_flag_group_decompressor_top: FAILED **");
        end
        $finish;
    end

endmodule
